[rtl/gcd_pkg.sv]
// ----------------------------------------------------------------------------
// gcd_pkg: shared types and constants for graph cycle detection
// Node limits, opcodes, register indexes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package gcd_pkg;
  localparam int MaxNodes = 16;
  localparam int NodeW    = $clog2(MaxNodes);
  localparam int CountW   = $clog2(MaxNodes + 1);

  localparam logic [1:0] OpAdd   = 2'd0;
  localparam logic [1:0] OpCheck = 2'd1;
  localparam logic [1:0] OpClear = 2'd2;

  localparam logic [0:0] RegMode  = 1'd0;
  localparam logic [0:0] RegCount = 1'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_SCAN,
    ST_STEP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic do_add;
    logic do_clear;
    logic init;
    logic seek_start;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic start_found;
    logic starts_done;
    logic stack_empty;
    logic cycle_found;
  } status_t;
endpackage

[rtl/gcd_if.sv]
// ----------------------------------------------------------------------------
// gcd_if: valid/ready channels
// Carry items into and results out of the graph cycle detect block.
// ----------------------------------------------------------------------------
interface gcd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [3:0] edge_from;
  logic [3:0] edge_to;
  modport source(output valid, op, edge_from, edge_to, input ready);
  modport sink(input valid, op, edge_from, edge_to, output ready);
endinterface

interface gcd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] result_kind;
  logic       edge_accepted;
  logic       has_cycle;
  modport source(output valid, result_kind, edge_accepted, has_cycle, input ready);
  modport sink(input valid, result_kind, edge_accepted, has_cycle, output ready);
endinterface

[rtl/gcd_datapath.sv]
// ----------------------------------------------------------------------------
// gcd_datapath: adjacency matrix and depth-first search engine
// One DFS step per command: scan the top row, push, pop, skip or flag a cycle.
// ----------------------------------------------------------------------------
module gcd_datapath import gcd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  input  logic              undirected_mode,
  input  logic [CountW-1:0] n_active,
  input  logic [NodeW-1:0]  edge_from,
  input  logic [NodeW-1:0]  edge_to,
  output status_t           status
);
  logic [MaxNodes-1:0] adjacency [MaxNodes];
  logic [MaxNodes-1:0] visited;
  logic [MaxNodes-1:0] on_path;
  logic [NodeW-1:0]    stack_node [MaxNodes];
  logic [CountW-1:0]   stack_scan_pos [MaxNodes];
  logic [CountW-1:0]   stack_depth;
  logic [CountW-1:0]   start;

  logic [NodeW-1:0]    top;
  logic [NodeW-1:0]    u;
  logic [CountW-1:0]   p;
  logic [MaxNodes-1:0] row;
  logic [MaxNodes-1:0] in_range;
  logic [MaxNodes-1:0] cand;
  logic                found;
  logic [NodeW-1:0]    v;
  logic                is_parent;
  logic                hit;
  logic [NodeW-1:0]    start_node;

  assign start_node = start[NodeW-1:0];
  assign top = stack_depth[NodeW-1:0] - 1'b1;
  assign u   = stack_node[top];
  assign p   = stack_scan_pos[top];
  assign row = adjacency[u];

  always_comb begin
    for (int i = 0; i < MaxNodes; i++) begin
      in_range[i] = (CountW'(i) >= p) && (CountW'(i) < n_active);
    end
    cand  = row & in_range;
    found = |cand;
    v     = '0;
    for (int i = MaxNodes - 1; i >= 0; i--) begin
      if (cand[i]) v = NodeW'(i);
    end
  end

  assign is_parent = (stack_depth > CountW'(1)) && (stack_node[top - 1'b1] == v);
  assign hit = (stack_depth != '0) && found && visited[v] &&
               (undirected_mode ? !is_parent : on_path[v]);

  assign status.start_found = (start < n_active) && !visited[start_node];
  assign status.starts_done = (start >= n_active);
  assign status.stack_empty = (stack_depth == '0);
  assign status.cycle_found = hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MaxNodes; i++) adjacency[i] <= '0;
      visited     <= '0;
      on_path     <= '0;
      stack_depth <= '0;
      start       <= '0;
    end else begin
      if (cmd.do_clear) begin
        for (int i = 0; i < MaxNodes; i++) adjacency[i] <= '0;
      end
      if (cmd.do_add) begin
        adjacency[edge_from][edge_to] <= 1'b1;
        if (undirected_mode) adjacency[edge_to][edge_from] <= 1'b1;
      end
      if (cmd.init) begin
        visited     <= '0;
        on_path     <= '0;
        stack_depth <= '0;
        start       <= '0;
      end
      if (cmd.seek_start) begin
        if (status.start_found) begin
          visited[start_node]    <= 1'b1;
          on_path[start_node]    <= 1'b1;
          stack_node[0]          <= start_node;
          stack_scan_pos[0]      <= '0;
          stack_depth            <= CountW'(1);
        end
        start <= start + 1'b1;
      end
      if (cmd.step) begin
        if (!found) begin
          stack_scan_pos[top] <= n_active;
          on_path[u]          <= 1'b0;
          stack_depth         <= stack_depth - 1'b1;
        end else begin
          stack_scan_pos[top] <= CountW'(v) + 1'b1;
          if (!visited[v] && stack_depth < CountW'(MaxNodes)) begin
            visited[v]                           <= 1'b1;
            on_path[v]                           <= 1'b1;
            stack_node[stack_depth[NodeW-1:0]]     <= v;
            stack_scan_pos[stack_depth[NodeW-1:0]] <= '0;
            stack_depth                          <= stack_depth + 1'b1;
          end
        end
      end
    end
  end
endmodule

[rtl/gcd_ctrl.sv]
// ----------------------------------------------------------------------------
// gcd_ctrl: item sequencer
// Accepts items, drives datapath commands, holds the result register.
// ----------------------------------------------------------------------------
module gcd_ctrl import gcd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        op,
  input  logic [NodeW-1:0]  edge_from,
  input  logic [NodeW-1:0]  edge_to,
  input  logic [CountW-1:0] n_active,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        result_kind,
  output logic              edge_accepted,
  output logic              has_cycle,
  output cmd_t              cmd,
  input  status_t           status
);
  state_t state, state_next;
  logic   take;
  logic   add_ok;
  logic   finish;
  logic   pend_cycle;

  assign add_ok   = (CountW'(edge_from) < n_active) && (CountW'(edge_to) < n_active);
  assign in_ready = (state == ST_IDLE) && (!out_valid || out_ready);
  assign take     = in_valid && in_ready;
  assign finish   = (state == ST_STEP && status.cycle_found) ||
                    (state == ST_START && status.starts_done);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (take && op == OpCheck) state_next = ST_START;
      ST_START: begin
        if (status.starts_done) state_next = ST_DONE;
        else if (status.start_found) state_next = ST_STEP;
      end
      ST_STEP: begin
        if (status.cycle_found) state_next = ST_DONE;
        else if (status.stack_empty) state_next = ST_START;
      end
      ST_DONE:  if (!out_valid || out_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE: begin
        cmd.do_add   = take && op == OpAdd && add_ok;
        cmd.do_clear = take && op == OpClear;
        cmd.init     = take && op == OpCheck;
      end
      ST_START: cmd.seek_start = !status.starts_done;
      ST_STEP:  cmd.step = !status.stack_empty && !status.cycle_found;
      default:  cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (finish) pend_cycle <= status.cycle_found;
      if (take && op != OpCheck) begin
        out_valid     <= 1'b1;
        result_kind   <= op;
        edge_accepted <= (op == OpAdd) && add_ok;
        has_cycle     <= 1'b0;
      end else if (state == ST_DONE && (!out_valid || out_ready)) begin
        out_valid     <= 1'b1;
        result_kind   <= OpCheck;
        edge_accepted <= 1'b0;
        has_cycle     <= pend_cycle;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end
endmodule

[rtl/graph_cycle_detect_unit.sv]
// ----------------------------------------------------------------------------
// graph_cycle_detect_unit: cycle detection on an adjacency bit matrix
// Add, clear and unused ops answer in the cycle after the transfer. A check runs
// a depth-first search: it tries each start node in turn, scans the top node's
// row for the next neighbor, pushes an unvisited one, pops a node whose row is
// exhausted and stops at the first cycle found or when all start nodes are done;
// input stalls until the result transfers.
// ----------------------------------------------------------------------------
module graph_cycle_detect_unit import gcd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  gcd_in_if.sink      in_ch,
  gcd_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:2]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic              undirected_mode;
  logic [4:0]        node_count;
  logic [CountW-1:0] n_active;
  cmd_t              cmd;
  status_t           status;

  assign pready = 1'b1;
  assign n_active = (node_count > 5'(MaxNodes)) ? CountW'(MaxNodes) : CountW'(node_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      undirected_mode <= 1'b1;
      node_count      <= 5'd16;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == RegMode) undirected_mode <= pwdata[0];
      else                     node_count      <= pwdata[4:0];
    end
  end

  assign prdata = (paddr[2] == RegCount) ? {27'd0, node_count} : {31'd0, undirected_mode};

  gcd_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .op(in_ch.op),
    .edge_from(in_ch.edge_from), .edge_to(in_ch.edge_to), .n_active,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .result_kind(out_ch.result_kind), .edge_accepted(out_ch.edge_accepted),
    .has_cycle(out_ch.has_cycle), .cmd, .status
  );

  gcd_datapath u_dp (
    .clk, .rst, .cmd, .undirected_mode, .n_active,
    .edge_from(in_ch.edge_from), .edge_to(in_ch.edge_to), .status
  );
endmodule

[rtl/gcd_checker.sv]
// ----------------------------------------------------------------------------
// gcd_checker: port-level checks
// Result fields stay consistent with their kind; stalled results keep kind.
// ----------------------------------------------------------------------------
module gcd_checker import gcd_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] result_kind,
  input logic       edge_accepted,
  input logic       has_cycle
);
  a_acc_only_add: assert property (@(posedge clk) disable iff (rst)
    out_valid && edge_accepted |-> result_kind == OpAdd) else $error("accept on non-add");
  a_cyc_only_chk: assert property (@(posedge clk) disable iff (rst)
    out_valid && has_cycle |-> result_kind == OpCheck) else $error("cycle on non-check");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_kind)) else $error("result dropped");
  a_busy_while_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready) else $error("input taken while result waits");
endmodule

bind graph_cycle_detect_unit gcd_checker u_gcd_checker (
  .clk, .rst,
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .result_kind(out_ch.result_kind), .edge_accepted(out_ch.edge_accepted),
  .has_cycle(out_ch.has_cycle)
);

[tb/tb_graph_cycle_detect_unit.sv]
// ----------------------------------------------------------------------------
// tb_graph_cycle_detect_unit: self-checking bench for graph cycle detection
// Loads edge, check, clear and unused ops through the input channel under
// several mode/node-count settings written over the register port. A local
// matrix and search predict each result, and the monitor compares every
// output transfer in order. Sender bursts and receiver stalls are random.
// ----------------------------------------------------------------------------
module tb_graph_cycle_detect_unit;
  import gcd_pkg::*;

  localparam logic [1:0] OpUnused = 2'd3;

  typedef struct {
    logic [1:0] op;
    logic [3:0] src;
    logic [3:0] dst;
  } graph_cmd_t;

  typedef struct {
    logic [1:0] kind;
    logic       accepted;
    logic       cycle;
  } graph_resp_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:2]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  gcd_in_if  in_ch ();
  gcd_out_if out_ch ();

  graph_cycle_detect_unit dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  graph_cmd_t  cmd_q[$];
  graph_resp_t resp_q[$];
  graph_cmd_t  cur_cmd;
  logic [15:0] adj_rows[16];
  logic        mdl_undirected;
  logic [4:0]  mdl_count;
  int          burst_left;
  int          gap_left;
  int          stall_mode;
  int          cyc_cnt;
  bit          failed;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic int active_nodes();
    return (mdl_count > 16) ? 16 : int'(mdl_count);
  endfunction

  function automatic bit graph_has_cycle();
    int n;
    int top;
    int u;
    int p;
    int v;
    int depth;
    bit found;
    logic [15:0] vis;
    logic [15:0] path;
    int snode[16];
    int spos[16];
    n = active_nodes();
    vis = '0;
    path = '0;
    for (int s = 0; s < n; s++) begin
      if (vis[s]) continue;
      vis[s] = 1'b1;
      path[s] = 1'b1;
      snode[0] = s;
      spos[0] = 0;
      depth = 1;
      while (depth > 0) begin
        top = depth - 1;
        u = snode[top];
        p = spos[top];
        found = 1'b0;
        v = 0;
        while (p < n) begin
          if (adj_rows[u][p]) begin
            found = 1'b1;
            v = p;
            p++;
            break;
          end
          p++;
        end
        spos[top] = p;
        if (!found) begin
          path[u] = 1'b0;
          depth--;
          continue;
        end
        if (!vis[v]) begin
          if (depth < 16) begin
            vis[v] = 1'b1;
            path[v] = 1'b1;
            snode[depth] = v;
            spos[depth] = 0;
            depth++;
          end
        end else if (mdl_undirected) begin
          if (!(top > 0 && snode[top - 1] == v)) return 1'b1;
        end else if (path[v]) begin
          return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  task automatic predict_graph_resp(input graph_cmd_t c);
    graph_resp_t r;
    int n;
    r.kind = c.op;
    r.accepted = 1'b0;
    r.cycle = 1'b0;
    n = active_nodes();
    case (c.op)
      OpAdd: begin
        if (c.src < n && c.dst < n) begin
          adj_rows[c.src][c.dst] = 1'b1;
          if (mdl_undirected) adj_rows[c.dst][c.src] = 1'b1;
          r.accepted = 1'b1;
        end
      end
      OpCheck: r.cycle = graph_has_cycle();
      OpClear: for (int i = 0; i < 16; i++) adj_rows[i] = '0;
      default: ;
    endcase
    resp_q.insert(resp_q.size(), r);
  endtask

  // sender: bursts with random gaps
  always @(posedge clk) begin : sender
    logic nv;
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.op <= OpAdd;
      in_ch.edge_from <= '0;
      in_ch.edge_to <= '0;
      burst_left <= 1;
      gap_left <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) predict_graph_resp(cur_cmd);
      if (!in_ch.valid || in_ch.ready) begin
        nv = 1'b0;
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else if (cmd_q.size() > 0) begin
          cur_cmd = cmd_q.pop_front();
          nv = 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
        in_ch.valid <= nv;
        in_ch.op <= cur_cmd.op;
        in_ch.edge_from <= cur_cmd.src;
        in_ch.edge_to <= cur_cmd.dst;
      end
    end
  end

  // receiver stall pattern and result check
  always @(posedge clk) begin : receiver
    graph_resp_t e;
    if (rst) begin
      out_ch.ready <= 1'b0;
      stall_mode <= 0;
      cyc_cnt <= 0;
    end else begin
      cyc_cnt <= cyc_cnt + 1;
      if (cyc_cnt % 97 == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= $urandom_range(0, 1);
        2: out_ch.ready <= (cyc_cnt % 8) < 2;
        default: out_ch.ready <= $urandom_range(0, 9) == 0;
      endcase
      if (out_ch.valid && out_ch.ready) begin
        if (resp_q.size() == 0) begin
          $error("unexpected result transfer kind=%0d", out_ch.result_kind);
          failed = 1'b1;
        end else begin
          e = resp_q.pop_front();
          if (out_ch.result_kind !== e.kind) begin
            $error("result_kind exp=%0d got=%0d", e.kind, out_ch.result_kind);
            failed = 1'b1;
          end
          if (out_ch.edge_accepted !== e.accepted) begin
            $error("edge_accepted exp=%0d got=%0d", e.accepted, out_ch.edge_accepted);
            failed = 1'b1;
          end
          if (out_ch.has_cycle !== e.cycle) begin
            $error("has_cycle exp=%0d got=%0d", e.cycle, out_ch.has_cycle);
            failed = 1'b1;
          end
        end
      end
    end
  end

  task automatic reg_write(input logic [0:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= idx;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == RegMode) mdl_undirected = val[0];
    else mdl_count = val[4:0];
  endtask

  task automatic push_cmd(input logic [1:0] op, input int s, input int d);
    graph_cmd_t c;
    c.op = op;
    c.src = s[3:0];
    c.dst = d[3:0];
    cmd_q.insert(cmd_q.size(), c);
  endtask

  task automatic wait_drained();
    while (cmd_q.size() > 0 || in_ch.valid || resp_q.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic push_random(input int cnt, input int span);
    int r;
    int hi;
    for (int i = 0; i < cnt; i++) begin
      r = $urandom_range(0, 99);
      hi = (r < 8) ? 15 : span;
      if (r < 72) push_cmd(OpAdd, $urandom_range(0, hi), $urandom_range(0, hi));
      else if (r < 90) push_cmd(OpCheck, $urandom_range(0, 15), $urandom_range(0, 15));
      else if (r < 97) push_cmd(OpClear, $urandom_range(0, 15), $urandom_range(0, 15));
      else push_cmd(OpUnused, $urandom_range(0, 15), $urandom_range(0, 15));
    end
  endtask

  initial begin : stimulus
    int modes[8] = '{0, 1, 0, 1, 0, 1, 0, 1};
    int counts[8] = '{16, 4, 2, 1, 0, 31, 9, 16};
    int span;
    failed = 1'b0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    mdl_undirected = 1'b1;
    mdl_count = 5'd16;
    cur_cmd = '{OpAdd, 4'd0, 4'd0};
    for (int i = 0; i < 16; i++) adj_rows[i] = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed cases in undirected mode: empty, parallel edges, self-loop, triangle, unused op
    push_cmd(OpCheck, 0, 0);
    push_cmd(OpAdd, 0, 1);
    push_cmd(OpAdd, 1, 0);
    push_cmd(OpCheck, 15, 15);
    push_cmd(OpAdd, 15, 15);
    push_cmd(OpCheck, 0, 0);
    push_cmd(OpClear, 0, 0);
    push_cmd(OpUnused, 15, 15);
    push_cmd(OpAdd, 0, 15);
    push_cmd(OpAdd, 15, 7);
    push_cmd(OpCheck, 0, 0);
    push_cmd(OpAdd, 7, 0);
    push_cmd(OpCheck, 0, 0);
    wait_drained();
    // mode change after loading, then count lowered
    reg_write(RegMode, 32'd0);
    push_cmd(OpCheck, 0, 0);
    push_cmd(OpClear, 0, 0);
    push_cmd(OpAdd, 1, 2);
    push_cmd(OpAdd, 2, 1);
    push_cmd(OpCheck, 0, 0);
    push_cmd(OpAdd, 3, 3);
    wait_drained();
    reg_write(RegCount, 32'd3);
    push_cmd(OpCheck, 0, 0);
    push_cmd(OpAdd, 3, 0);
    push_cmd(OpAdd, 0, 3);
    push_cmd(OpClear, 0, 0);
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      reg_write(RegMode, modes[ph]);
      reg_write(RegCount, counts[ph]);
      span = (counts[ph] == 0) ? 0 : ((counts[ph] > 16) ? 15 : counts[ph] - 1);
      push_random(125, span);
      wait_drained();
    end
    repeat (300) @(posedge clk);
    if (!failed && resp_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

[filelist.f]
rtl/gcd_pkg.sv
rtl/gcd_if.sv
rtl/gcd_datapath.sv
rtl/gcd_ctrl.sv
rtl/graph_cycle_detect_unit.sv
rtl/gcd_checker.sv
tb/tb_graph_cycle_detect_unit.sv
